[sv/ising_metropolis_spin_update_core_assert.svh]
// Assertion helpers shared by the spin update core.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_CORE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define ISING_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ISING_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/isingmsu_pkg.sv]
package isingmsu_pkg;

    // Side lengths up to 511 are handled in this width.
    localparam int SIDE_W       = 9;
    localparam int MAX_SIDE_DEF = 64;

    localparam int ROW_W    = 6;
    localparam int FRAC_W   = 16;
    localparam int GRID_W   = 7;
    localparam int COUP_W   = 8;
    localparam int THR_W    = 17;
    localparam int DE_W     = 12;
    localparam int UPC_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam logic [GRID_W-1:0] GRID_RESET     = 7'd64;
    localparam logic [COUP_W-1:0] COUPLING_RESET = 8'sd1;
    localparam logic [THR_W-1:0]  THR_RESET      = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_NEG4  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_NEG2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_POS2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_POS4  = 3'd5;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Active side: grid_size held within 2 .. max_side.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [GRID_W-1:0] grid,
                                                     input logic [SIDE_W-1:0] max_side);
        logic [SIDE_W-1:0] g;
        g = {{(SIDE_W-GRID_W){1'b0}}, grid};
        if (g < SIDE_W'(2)) begin
            return SIDE_W'(2);
        end else if (g > max_side) begin
            return max_side;
        end
        return g;
    endfunction

endpackage

[sv/ising_metropolis_spin_update_core.sv]
// Metropolis spin update for a square Ising lattice with wrap-around edges.
// Each row of the lattice is one word of the spin store, held as two
// identical copies so that the site's row and both neighbouring rows are
// read together. For each item the rows are read in the cycle the item is
// accepted, and in the next the flip is decided, the row written back to
// both copies and the result loaded into the output register. The next
// item is taken only after that, and only while the output register is
// empty or being read. After reset a clearing pass writes every row to
// all down; no item is taken during it, while configuration writes are
// always taken. Configuration must only be written while no item is in
// flight.
`include "ising_metropolis_spin_update_core_assert.svh"

module ising_metropolis_spin_update_core
    import isingmsu_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Item input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: row[5:0], column[11:6], random_fraction[27:12], spin_value[28]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command[0]
    input  logic [0:0]            s_axis_tuser,
    // Result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: flipped[0], energy_change[12:1], spin_after[13], up_count[26:14]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW    = $clog2(MAX_SIDE);
    localparam int CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam logic [RW-1:0]     LAST_ROW = RW'(MAX_SIDE - 1);
    localparam logic [SIDE_W-1:0] MAX_S    = SIDE_W'(MAX_SIDE);

    // Configuration registers
    logic [SIDE_W-1:0] r_side;
    logic [COUP_W-1:0] r_coupling;
    logic [THR_W-1:0]  r_thr_neg4, r_thr_neg2, r_thr_pos2, r_thr_pos4;

    // Control and item context
    t_state             r_state, n_state;
    logic [RW-1:0]      r_clr_row;
    logic [CNT_W-1:0]   r_up_count, n_up_count;
    logic               r_cmd, r_in_range, r_sv;
    logic [FRAC_W-1:0]  r_frac;
    logic [RW-1:0]      r_row, r_col, r_cp, r_cm;

    // Output register
    logic               r_out_valid;
    logic               r_out_flipped, n_out_flipped;
    logic [DE_W-1:0]    r_out_de, n_out_de;
    logic               r_out_after, n_out_after;
    logic [UPC_W-1:0]   r_out_upc;

    // Input fields
    logic [ROW_W-1:0]   w_in_row, w_in_col;
    logic [FRAC_W-1:0]  w_in_frac;
    logic               w_in_sv, w_in_cmd, w_accept;
    logic [SIDE_W-1:0]  w_row9, w_col9, w_rp9, w_rm9, w_cp9, w_cm9;
    logic               w_in_range;

    // Store access
    logic               w_we;
    logic [RW-1:0]      w_waddr;
    logic [MAX_SIDE-1:0] w_wdata, w_new_row;
    logic [MAX_SIDE-1:0] w_row_r, w_row_p, w_row_m, w_row_chk;

    // Decision
    logic               w_cur, w_new_spin;
    logic [2:0]         w_ups, w_k;
    logic signed [DE_W-1:0] w_j, w_de;
    logic [THR_W-1:0]   w_thr;
    logic               w_go;
    logic [CNT_W+UPC_W-1:0] w_cnt_wide;

    assign w_in_row  = s_axis_tdata[5:0];
    assign w_in_col  = s_axis_tdata[11:6];
    assign w_in_frac = s_axis_tdata[27:12];
    assign w_in_sv   = s_axis_tdata[28];
    assign w_in_cmd  = s_axis_tuser[0];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Wrapped neighbour coordinates, worked out as the item arrives.
    always_comb begin
        w_row9 = {{(SIDE_W-ROW_W){1'b0}}, w_in_row};
        w_col9 = {{(SIDE_W-ROW_W){1'b0}}, w_in_col};
        w_in_range = (w_row9 < r_side) && (w_col9 < r_side);
        w_rp9 = (w_row9 + SIDE_W'(1) == r_side) ? '0 : w_row9 + SIDE_W'(1);
        w_rm9 = (w_row9 == '0) ? r_side - SIDE_W'(1) : w_row9 - SIDE_W'(1);
        w_cp9 = (w_col9 + SIDE_W'(1) == r_side) ? '0 : w_col9 + SIDE_W'(1);
        w_cm9 = (w_col9 == '0) ? r_side - SIDE_W'(1) : w_col9 - SIDE_W'(1);
    end

    // Two identical copies: copy A gives the site row and the row below,
    // copy B the row above and a second view of the site row.
    isingmsu_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE),
        .AW    (RW)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_row9[RW-1:0]),
        .i_raddr_b (w_rp9[RW-1:0]),
        .o_rdata_a (w_row_r),
        .o_rdata_b (w_row_p)
    );

    isingmsu_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE),
        .AW    (RW)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_rm9[RW-1:0]),
        .i_raddr_b (w_row9[RW-1:0]),
        .o_rdata_a (w_row_m),
        .o_rdata_b (w_row_chk)
    );

    // Flip decision on the rows just read.
    always_comb begin
        w_cur = w_row_r[r_col];
        w_ups = 3'(w_row_p[r_col]) + 3'(w_row_m[r_col])
              + 3'(w_row_r[r_cp]) + 3'(w_row_r[r_cm]);
        // k = (s*sum + 4)/2, so the level is 2k-4
        w_k = w_cur ? w_ups : 3'd4 - w_ups;
        w_j = {{(DE_W-COUP_W){r_coupling[COUP_W-1]}}, r_coupling};
        case (w_k)
            3'd0:    w_de = -(w_j <<< 3);
            3'd1:    w_de = -(w_j <<< 2);
            3'd3:    w_de = w_j <<< 2;
            3'd4:    w_de = w_j <<< 3;
            default: w_de = '0;
        endcase
        case (w_k)
            3'd0:    w_thr = r_thr_neg4;
            3'd1:    w_thr = r_thr_neg2;
            3'd3:    w_thr = r_thr_pos2;
            default: w_thr = r_thr_pos4;
        endcase
        // A non-positive change always flips.
        w_go = (w_de <= 0) || ({1'b0, r_frac} < w_thr);

        if (r_cmd == CMD_SET) begin
            w_new_spin    = r_sv;
            n_out_flipped = w_cur ^ r_sv;
            n_out_de      = '0;
        end else begin
            w_new_spin    = w_go ? ~w_cur : w_cur;
            n_out_flipped = w_go;
            n_out_de      = w_de;
        end
        if (!r_in_range) begin
            n_out_flipped = 1'b0;
            n_out_de      = '0;
        end
        n_out_after = r_in_range && w_new_spin;

        w_new_row = w_row_r;
        w_new_row[r_col] = w_new_spin;

        n_up_count = r_up_count;
        if (r_in_range && (w_new_spin != w_cur)) begin
            n_up_count = w_new_spin ? r_up_count + CNT_W'(1) : r_up_count - CNT_W'(1);
        end
        w_cnt_wide = {{UPC_W{1'b0}}, n_up_count};
    end

    // Sequencer: next state and store write port.
    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = r_row;
        w_wdata = w_new_row;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_row;
                w_wdata = '0;
                if (r_clr_row == LAST_ROW) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                w_we    = r_in_range;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row   <= '0;
            r_up_count  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + RW'(1);
            end
            if (r_state == ST_EXEC) begin
                r_up_count  <= n_up_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= w_in_cmd;
            r_in_range <= w_in_range;
            r_sv       <= w_in_sv;
            r_frac     <= w_in_frac;
            r_row      <= w_row9[RW-1:0];
            r_col      <= w_col9[RW-1:0];
            r_cp       <= w_cp9[RW-1:0];
            r_cm       <= w_cm9[RW-1:0];
        end
        if (r_state == ST_EXEC) begin
            r_out_flipped <= n_out_flipped;
            r_out_de      <= n_out_de;
            r_out_after   <= n_out_after;
            r_out_upc     <= w_cnt_wide[UPC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= clamp_side(GRID_RESET, MAX_S);
            r_coupling <= COUPLING_RESET;
            r_thr_neg4 <= THR_RESET;
            r_thr_neg2 <= THR_RESET;
            r_thr_pos2 <= THR_RESET;
            r_thr_pos4 <= THR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_GRID_SIZE: r_side     <= clamp_side(i_cfg_data[GRID_W-1:0], MAX_S);
                CFG_COUPLING:  r_coupling <= i_cfg_data[COUP_W-1:0];
                CFG_THR_NEG4:  r_thr_neg4 <= i_cfg_data[THR_W-1:0];
                CFG_THR_NEG2:  r_thr_neg2 <= i_cfg_data[THR_W-1:0];
                CFG_THR_POS2:  r_thr_pos2 <= i_cfg_data[THR_W-1:0];
                CFG_THR_POS4:  r_thr_pos4 <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-27){1'b0}}, r_out_upc, r_out_after,
                            r_out_de, r_out_flipped};

    `ISING_ASSERT_IMP(a_copies_agree, i_clk, i_rst_n, r_state == ST_EXEC && r_in_range, w_row_chk == w_row_r, "spin store copies disagree on the site row")
    `ISING_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == ST_EXEC && !r_out_valid, "accepted item did not move to execution with an empty output")
    `ISING_ASSERT_NXT(a_count_stable, i_clk, i_rst_n, r_state != ST_EXEC, $stable(r_up_count), "up count changed outside item execution")
    `ISING_ASSERT_NXT(a_outside_quiet, i_clk, i_rst_n, r_state == ST_EXEC && !r_in_range, r_out_valid && !r_out_flipped && r_out_de == '0 && !r_out_after, "site outside the lattice gave a non-empty result")

endmodule

[sv/isingmsu_ram.sv]
module isingmsu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
